[rtl/scl_pkg.sv]
package scl_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_BLK_OFF    = 2'd0;
	localparam logic [1:0] REG_INDEX_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS_USED  = 2'd2;
	localparam logic [1:0] REG_POLICY     = 2'd3;

	// Replacement policy codes
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	// Lookup outcome codes
	localparam logic [1:0] OUT_HIT  = 2'd0;
	localparam logic [1:0] OUT_FILL = 2'd1;
	localparam logic [1:0] OUT_REPL = 2'd2;

	// Raw set index width (index_bits is at most 7)
	localparam int IDX_RAW_W = 7;

	typedef struct packed {
		logic [4:0] blk_off;
		logic [2:0] index_bits;
		logic [3:0] ways_used;
		logic       policy;
	} cfg_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic       hit;
		logic       miss;
	} upd_status_t;

endpackage

[rtl/scl_ram.sv]
module scl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/scl_addr_split.sv]
module scl_addr_split #(
	parameter int ADDR_WIDTH = 32,
	parameter int MAX_SETS   = 64
) (
	input  logic [31:0]                                      address,
	input  scl_pkg::cfg_t                                    cfg,
	output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] set,
	output logic [ADDR_WIDTH-1:0]                            tag
);

	import scl_pkg::*;

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int RAW_N = 1 << IDX_RAW_W;
	localparam logic [6:0] AW_L = 7'(ADDR_WIDTH);

	// raw index -> set number modulo the set count, built at elaboration
	function automatic logic [RAW_N*SET_W-1:0] set_tab_init();
		logic [RAW_N*SET_W-1:0] t;
		t = '0;
		for (int i = 0; i < RAW_N; i++) begin
			t[i*SET_W +: SET_W] = SET_W'(i % MAX_SETS);
		end
		return t;
	endfunction

	localparam logic [RAW_N*SET_W-1:0] SET_TAB = set_tab_init();

	logic [ADDR_WIDTH-1:0] addr_m;
	logic [ADDR_WIDTH-1:0] idx_sh;
	logic [IDX_RAW_W-1:0]  idx_mask;
	logic [IDX_RAW_W-1:0]  idx_raw;
	logic [5:0]            tag_sh;

	assign addr_m   = address[ADDR_WIDTH-1:0];
	assign idx_sh   = addr_m >> cfg.blk_off;
	assign idx_mask = IDX_RAW_W'((8'd1 << cfg.index_bits) - 8'd1);
	assign idx_raw  = idx_sh[IDX_RAW_W-1:0] & idx_mask;

	// Set number modulo the set count: constant table over the raw index
	assign set = SET_TAB[idx_raw*SET_W +: SET_W];

	// Tag vanishes once offset plus index covers the whole address
	assign tag_sh = {1'b0, cfg.blk_off} + {3'b000, cfg.index_bits};
	assign tag    = ({1'b0, tag_sh} >= AW_L) ? '0 : (addr_m >> tag_sh);

endmodule

[rtl/scl_update.sv]
module scl_update #(
	parameter int MAX_WAYS   = 8,
	parameter int ADDR_WIDTH = 32
) (
	input  logic [MAX_WAYS*(ADDR_WIDTH+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+1)
	              + ((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] row_rd,
	input  logic                                                row_init,
	input  logic [ADDR_WIDTH-1:0]                               tag,
	input  scl_pkg::cfg_t                                       cfg,
	output logic [MAX_WAYS*(ADDR_WIDTH+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+1)
	              + ((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] row_wr,
	output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]  way,
	output scl_pkg::upd_status_t                                status
);

	import scl_pkg::*;

	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int CNT_W  = $clog2(MAX_WAYS + 1);
	localparam int TAGS_LO  = 0;
	localparam int RANKS_LO = MAX_WAYS * ADDR_WIDTH;
	localparam int VALID_LO = RANKS_LO + MAX_WAYS * RANK_W;
	localparam int PTR_LO   = VALID_LO + MAX_WAYS;
	localparam logic [4:0] MAXW_L = 5'(MAX_WAYS);

	logic [ADDR_WIDTH-1:0] tags     [MAX_WAYS];
	logic [RANK_W-1:0]     ranks    [MAX_WAYS];
	logic [RANK_W-1:0]     new_ranks[MAX_WAYS];
	logic [ADDR_WIDTH-1:0] new_tags [MAX_WAYS];
	logic [MAX_WAYS-1:0]   valid;
	logic [MAX_WAYS-1:0]   new_valid;
	logic [WAY_W-1:0]      ptr;
	logic [WAY_W-1:0]      new_ptr;
	logic [4:0]            wn;
	logic [CNT_W-1:0]      n_valid;
	logic                  hit_f, empty_f;
	logic [WAY_W-1:0]      hit_w, empty_w, lru_w, fifo_w, fifo_nxt, sel;
	logic [RANK_W-1:0]     best_rank, sel_rank;

	// Row unpack; a set never written reads as all invalid, ranks and pointer zero
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			tags[w]  = row_rd[TAGS_LO + w*ADDR_WIDTH +: ADDR_WIDTH];
			ranks[w] = row_init ? row_rd[RANKS_LO + w*RANK_W +: RANK_W] : '0;
		end
		valid = row_init ? row_rd[VALID_LO +: MAX_WAYS] : '0;
		ptr   = row_init ? row_rd[PTR_LO +: WAY_W] : '0;
	end

	// Active way count, clamped to 1..MAX_WAYS
	always_comb begin
		wn = {1'b0, cfg.ways_used};
		if (wn == 5'd0) begin
			wn = 5'd1;
		end else if (wn > MAXW_L) begin
			wn = MAXW_L;
		end
	end

	always_comb begin
		n_valid = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			n_valid = n_valid + CNT_W'(valid[w]);
		end
	end

	// Parallel tag compare and first empty way
	always_comb begin
		hit_f   = 1'b0;
		hit_w   = '0;
		empty_f = 1'b0;
		empty_w = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (!hit_f && valid[w] && (5'(w) < wn) && (tags[w] == tag)) begin
				hit_f = 1'b1;
				hit_w = WAY_W'(w);
			end
			if (!empty_f && !valid[w] && (5'(w) < wn)) begin
				empty_f = 1'b1;
				empty_w = WAY_W'(w);
			end
		end
	end

	// LRU victim: lowest rank, earliest way on ties
	always_comb begin
		lru_w     = '0;
		best_rank = ranks[0];
		for (int w = 1; w < MAX_WAYS; w++) begin
			if ((5'(w) < wn) && (ranks[w] < best_rank)) begin
				lru_w     = WAY_W'(w);
				best_rank = ranks[w];
			end
		end
	end

	// FIFO victim and next pointer
	always_comb begin
		fifo_w   = (5'(ptr) >= wn) ? '0 : ptr;
		fifo_nxt = ((5'(fifo_w) + 5'd1) >= wn) ? '0 : WAY_W'(fifo_w + 1'b1);
	end

	always_comb begin
		status = '0;
		if (hit_f) begin
			sel            = hit_w;
			status.outcome = OUT_HIT;
			status.hit     = 1'b1;
		end else if (empty_f) begin
			sel            = empty_w;
			status.outcome = OUT_FILL;
		end else begin
			sel            = (cfg.policy == POLICY_FIFO) ? fifo_w : lru_w;
			status.outcome = OUT_REPL;
			status.miss    = 1'b1;
		end
	end

	// Row update: tag write, rank refresh, valid bit, pointer
	always_comb begin
		sel_rank  = ranks[sel];
		new_valid = valid;
		new_ptr   = ptr;
		for (int w = 0; w < MAX_WAYS; w++) begin
			new_tags[w]  = tags[w];
			new_ranks[w] = ranks[w];
		end
		if (!status.hit) begin
			new_tags[sel] = tag;
		end
		if (status.outcome == OUT_FILL) begin
			new_ranks[sel] = RANK_W'(n_valid);
			new_valid[sel] = 1'b1;
		end else begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				if ((WAY_W'(w) != sel) && valid[w] && (ranks[w] > sel_rank)) begin
					new_ranks[w] = ranks[w] - 1'b1;
				end
			end
			new_ranks[sel] = RANK_W'(n_valid - 1'b1);
		end
		if (status.miss && (cfg.policy == POLICY_FIFO)) begin
			new_ptr = fifo_nxt;
		end
	end

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			row_wr[TAGS_LO + w*ADDR_WIDTH +: ADDR_WIDTH] = new_tags[w];
			row_wr[RANKS_LO + w*RANK_W +: RANK_W]        = new_ranks[w];
		end
		row_wr[VALID_LO +: MAX_WAYS] = new_valid;
		row_wr[PTR_LO +: WAY_W]      = new_ptr;
	end

	assign way = sel;

endmodule

[rtl/set_associative_cache_lookup.sv]
// Set-associative cache tag lookup with LRU or FIFO replacement. Each input
// transaction carries one byte address; the block cuts it into offset, set
// and tag by the configured bit counts, compares the tag against all active
// ways of the set at once, and returns one result transaction: outcome (hit,
// fill of an empty way, or replacement), the way touched, and the running
// hit and miss counts after this access; a fill counts as neither. Each
// set lives in one row of a single-port-per-side set RAM (tags, LRU ranks,
// valid bits, FIFO pointer); an access reads its row, then compares, updates
// and writes it back, and no new address is taken before that write. A
// finished result sits in an output register, and the next address is taken
// while it waits. Sets never written read as empty through one init flop per
// set, so no clearing pass runs after reset. Configuration must be written
// only while no access is in flight; the block does not enforce it. Register
// 0 block offset width, 1 index_bits, 2 ways_used, 3 policy.
module set_associative_cache_lookup #(
	parameter int MAX_WAYS   = 8,
	parameter int MAX_SETS   = 64,
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	// address transactions in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] address
	// lookup results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [1:0] outcome, [4:2] way, [36:5] hit_total,
	                               // [68:37] miss_total, [71:69] zero
);

	import scl_pkg::*;

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ROW_W  = MAX_WAYS * (ADDR_WIDTH + WAY_W + 1) + WAY_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic                  state_q;
	cfg_t                  cfg_q;
	logic [MAX_SETS-1:0]   set_init_q;
	logic [SET_W-1:0]      set_w;
	logic [ADDR_WIDTH-1:0] tag_w;
	logic [SET_W-1:0]      set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic                  init_s1;
	logic [ROW_W-1:0]      row_rd, row_wr;
	logic [WAY_W-1:0]      upd_way;
	upd_status_t           upd_st;
	logic                  accept, commit;
	logic [31:0]           hit_q, miss_q, hit_nxt, miss_nxt;
	logic                  out_valid_q;
	logic [1:0]            out_outcome_q;
	logic [2:0]            out_way_q;
	logic [31:0]           out_hit_q, out_miss_q;
	logic [3:0]            way_ext;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blk_off    <= 5'd2;
			cfg_q.index_bits <= 3'd0;
			cfg_q.ways_used  <= 4'd1;
			cfg_q.policy     <= POLICY_FIFO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLK_OFF:    cfg_q.blk_off    <= cfg_data;
				REG_INDEX_BITS: cfg_q.index_bits <= cfg_data[2:0];
				REG_WAYS_USED:  cfg_q.ways_used  <= cfg_data[3:0];
				REG_POLICY:     cfg_q.policy     <= cfg_data[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	scl_addr_split #(
		.ADDR_WIDTH(ADDR_WIDTH),
		.MAX_SETS  (MAX_SETS)
	) u_split (
		.address(s_tdata),
		.cfg    (cfg_q),
		.set    (set_w),
		.tag    (tag_w)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// write back and hand over the result once the output register is free
	assign commit   = (state_q == ST_LOOK) && (!out_valid_q || m_tready);

	scl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_SETS)
	) u_set_ram (
		.clk  (clk),
		.we   (commit),
		.waddr(set_s1),
		.wdata(row_wr),
		.re   (accept),
		.raddr(set_w),
		.rdata(row_rd)
	);

	// Lookup stage registers; read data holds while the stage stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1  <= set_w;
			tag_s1  <= tag_w;
			init_s1 <= set_init_q[set_w];
		end
	end

	scl_update #(
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_update (
		.row_rd  (row_rd),
		.row_init(init_s1),
		.tag     (tag_s1),
		.cfg     (cfg_q),
		.row_wr  (row_wr),
		.way     (upd_way),
		.status  (upd_st)
	);

	assign hit_nxt  = hit_q + 32'(upd_st.hit);
	assign miss_nxt = miss_q + 32'(upd_st.miss);
	assign way_ext  = 4'(upd_way);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			set_init_q  <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				set_init_q[set_s1] <= 1'b1;
				hit_q              <= hit_nxt;
				miss_q             <= miss_nxt;
				out_valid_q        <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_outcome_q <= upd_st.outcome;
			out_way_q     <= way_ext[2:0];
			out_hit_q     <= hit_nxt;
			out_miss_q    <= miss_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_miss_q, out_hit_q, out_way_q, out_outcome_q};

endmodule

[sim/set_associative_cache_lookup_test.sv]
module set_associative_cache_lookup_test;
	import scl_pkg::*;

	localparam int CACHE_WAYS  = 8;
	localparam int CACHE_SETS  = 64;
	localparam int ITEM_TARGET = 850;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;

	// one lookup result, laid out as m_tdata[68:0]
	typedef struct packed {
		logic [31:0] misses;
		logic [31:0] hits;
		logic [2:0]  way;
		logic [1:0]  outcome;
	} lookup_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_BLK_OFF;
	logic [4:0]  cfg_data = 5'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;   // [31:0] address
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // [1:0] outcome, [4:2] way, [36:5] hit_total,
	                                // [68:37] miss_total

	set_associative_cache_lookup #(
		.MAX_WAYS(CACHE_WAYS),
		.MAX_SETS(CACHE_SETS),
		.ADDR_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// Cache state as the testbench sees it
	logic [31:0] line_tag [CACHE_SETS][CACHE_WAYS];
	logic [2:0]  line_age [CACHE_SETS][CACHE_WAYS];   // 0 = least recent
	logic [7:0]  line_valid [CACHE_SETS];
	logic [2:0]  fifo_next [CACHE_SETS];
	logic [31:0] hit_count = 32'd0;
	logic [31:0] miss_count = 32'd0;

	// Register values, same reset as the block
	logic [4:0] cache_offset = 5'd2;
	logic [2:0] cache_index = 3'd0;
	logic [3:0] cache_ways = 4'd1;
	logic       cache_policy = POLICY_FIFO;

	logic [31:0]    address_queue [$];
	lookup_result_t expected_results [$];

	int   error_count = 0;
	int   cycle_count = 0;
	int   item_total = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	bit   send_burst = 1'b0;
	bit   recv_burst = 1'b0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;

	// ways_used 0 acts as 1, anything past the array as the full array
	function automatic int unsigned active_ways();
		int unsigned wn;
		wn = cache_ways;
		if (wn < 1) wn = 1;
		if (wn > CACHE_WAYS) wn = CACHE_WAYS;
		return wn;
	endfunction

	// Move a way to the most recent rank among the valid ways of its row
	function automatic void make_recent(int unsigned row, int unsigned w);
		int unsigned v, n;
		logic [2:0] r;
		r = line_age[row][w];
		n = $countones(line_valid[row]);
		for (v = 0; v < CACHE_WAYS; v++)
			if (v != w && line_valid[row][v] && line_age[row][v] > r)
				line_age[row][v] = line_age[row][v] - 3'd1;
		line_age[row][w] = 3'(n - 1);
	endfunction

	// Lookup of one accepted address: updates the state, queues the result
	function automatic void predict_lookup(logic [31:0] addr);
		int unsigned wn, off, ib, row, w, way, best, n;
		logic [63:0] a;
		logic [31:0] tag;
		bit found, empty;
		lookup_result_t r;
		wn = active_ways();
		off = cache_offset;
		ib = cache_index;
		a = {32'd0, addr};
		// index_bits of 7 gives a raw set past the array, folded back by modulo
		row = 32'(((a >> off) & ((64'd1 << ib) - 64'd1)) % CACHE_SETS);
		// a shift of 32 or more leaves a zero tag
		tag = 32'(a >> (off + ib));
		found = 1'b0;
		way = 0;
		for (w = 0; w < wn && !found; w++)
			if (line_valid[row][w] && line_tag[row][w] == tag) begin
				found = 1'b1;
				way = w;
			end
		if (found) begin
			r.outcome = OUT_HIT;
			hit_count = hit_count + 32'd1;
			make_recent(row, way);
		end else begin
			empty = 1'b0;
			for (w = 0; w < wn && !empty; w++)
				if (!line_valid[row][w]) begin
					empty = 1'b1;
					way = w;
				end
			if (empty) begin
				// fill the lowest empty way, newest rank, no counter moves
				n = $countones(line_valid[row]);
				r.outcome = OUT_FILL;
				line_tag[row][way] = tag;
				line_valid[row][way] = 1'b1;
				line_age[row][way] = 3'(n);
			end else begin
				r.outcome = OUT_REPL;
				if (cache_policy == POLICY_LRU) begin
					// only active ways compete; shrunk-away ways keep their ranks
					best = 0;
					for (w = 1; w < wn; w++)
						if (line_age[row][w] < line_age[row][best])
							best = w;
					way = best;
				end else begin
					// stale pointer past the active ways falls back to way 0
					way = fifo_next[row];
					if (way >= wn) way = 0;
					fifo_next[row] = (way + 1 >= wn) ? 3'd0 : 3'(way + 1);
				end
				line_tag[row][way] = tag;
				make_recent(row, way);
				miss_count = miss_count + 32'd1;
			end
		end
		r.way = 3'(way);
		r.hits = hit_count;
		r.misses = miss_count;
		expected_results = {expected_results, r};
	endfunction

	// Address that lands on a given tag and raw set under the current cut
	function automatic logic [31:0] place_addr(logic [31:0] tag, int unsigned set_raw,
			logic [31:0] low);
		int unsigned off, ib;
		logic [63:0] a;
		off = cache_offset;
		ib = cache_index;
		a = ({32'd0, tag} << (off + ib)) | (64'(set_raw) << off) |
			({32'd0, low} & ((64'd1 << off) - 64'd1));
		return a[31:0];
	endfunction

	task automatic report_error(input string detail);
		error_count++;
		if (error_count <= 10)
			$display("%0t ERROR %s", $time, detail);
	endtask

	// ---------------- input side ----------------

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (address_queue.size() > 0) begin
				s_tdata <= address_queue.pop_front();
				s_tvalid <= 1'b1;
				gap_left = send_burst ? 0 : $urandom_range(0, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			predict_lookup(s_tdata);
	end

	// ---------------- output side ----------------

	// long hold-off of the receiver, started from the stimulus process
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
		end else if (out_fire || !m_tready) begin
			if (out_fire)
				stall_left = recv_burst ? 0 : $urandom_range(0, 6);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	lookup_result_t want, got;

	always @(posedge clk) begin
		out_fire <= m_tvalid && m_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[68:0];
			if (expected_results.size() == 0) begin
				report_error($sformatf("result with nothing pending: outcome %0d way %0d",
					got.outcome, got.way));
			end else begin
				want = expected_results.pop_front();
				if (got.outcome !== want.outcome || got.way !== want.way ||
						got.hits !== want.hits || got.misses !== want.misses)
					report_error($sformatf({"expected outcome %0d way %0d hits %0d misses %0d,",
						" got outcome %0d way %0d hits %0d misses %0d"},
						want.outcome, want.way, want.hits, want.misses,
						got.outcome, got.way, got.hits, got.misses));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BLK_OFF:    cache_offset = val;
			REG_INDEX_BITS: cache_index = val[2:0];
			REG_WAYS_USED:  cache_ways = val[3:0];
			REG_POLICY:     cache_policy = val[0];
			default:        ;
		endcase
	endtask

	task automatic set_config(input int unsigned off, input int unsigned ib,
			input int unsigned wn, input logic pol);
		write_reg(REG_BLK_OFF, 5'(off));
		write_reg(REG_INDEX_BITS, 5'(ib));
		write_reg(REG_WAYS_USED, 5'(wn));
		write_reg(REG_POLICY, {4'd0, pol});
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// all transactions out and answered, plus the block's latency
	task automatic wait_idle();
		@(posedge clk);
		while (address_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_addr(input logic [31:0] addr);
		address_queue = {address_queue, addr};
		item_total++;
	endtask

	// Mostly a few tags over a few sets so hits, fills and evictions all happen;
	// the rest are raw addresses that toggle every bit.
	task automatic push_random(input int count);
		int unsigned wn, span, near, set_raw;
		logic [31:0] tag_seed;
		wn = active_ways();
		span = 1 << cache_index;
		near = (span > 4) ? 4 : span;
		tag_seed = $urandom();
		repeat (count) begin
			if ($urandom_range(0, 4) == 0) begin
				push_addr($urandom());
			end else begin
				set_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) :
					$urandom_range(0, near - 1);
				push_addr(place_addr(tag_seed ^ $urandom_range(0, wn + 2), set_raw,
					$urandom()));
			end
		end
	endtask

	initial begin
		int phase;
		for (int s = 0; s < CACHE_SETS; s++) begin
			line_valid[s] = 8'd0;
			fifo_next[s] = 3'd0;
			for (int w = 0; w < CACHE_WAYS; w++) begin
				line_tag[s][w] = 32'd0;
				line_age[s][w] = 3'd0;
			end
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one way, FIFO; lowest and highest address
		push_addr(32'h0000_0000);
		push_addr(32'hFFFF_FFFF);
		push_addr(32'hFFFF_FFFF);
		wait_idle();

		// four ways LRU: fill, hit, then evict the two oldest
		set_config(4, 2, 4, POLICY_LRU);
		push_addr(place_addr(32'd10, 1, 32'h0));
		push_addr(place_addr(32'd11, 1, 32'hF));
		push_addr(place_addr(32'd12, 1, 32'h5));
		push_addr(place_addr(32'd13, 1, 32'hA));
		push_addr(place_addr(32'd10, 1, 32'h3));
		push_addr(place_addr(32'd14, 1, 32'h0));
		push_addr(place_addr(32'd11, 1, 32'h0));
		wait_idle();

		// same set under FIFO
		set_config(4, 2, 4, POLICY_FIFO);
		push_addr(place_addr(32'd15, 1, 32'h0));
		push_addr(place_addr(32'd16, 1, 32'h0));
		wait_idle();

		// zero ways, huge offset (tag always zero), index past the set array
		set_config(31, 7, 0, POLICY_FIFO);
		push_addr(32'h8000_0000);
		push_addr(32'h0000_0000);
		push_addr(32'h7FFF_FFFF);
		wait_idle();

		// ways field past the array: fill all eight, then two FIFO evictions
		set_config(0, 0, 15, POLICY_FIFO);
		for (int t = 1; t <= 9; t++)
			push_addr(place_addr(32'(t), 0, 32'h0));
		wait_idle();

		// shrink to two ways: FIFO pointer now past the active ways
		set_config(0, 0, 2, POLICY_FIFO);
		push_addr(place_addr(32'd20, 0, 32'h0));
		push_addr(place_addr(32'd1, 0, 32'h0));
		wait_idle();

		phase = 0;
		while (item_total < ITEM_TARGET) begin
			set_config(($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) :
				$urandom_range(0, 16), $urandom_range(0, 7), $urandom_range(0, 15),
				1'($urandom_range(0, 1)));
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// sender streams while the receiver stops: block backs up
				send_burst = 1'b1;
				hold_left <= HOLD_CYCLES;
			end
			push_random($urandom_range(30, 70));
			wait_idle();
			phase++;
		end

		if (error_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
